// ===== hdl/tcffa_pkg.sv =====
`default_nettype none

package tcffa_pkg;

  // Fixed widths of the command and result fields
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned STATUS_W  = 2;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Queue select
  localparam logic CH_REQUEST  = 1'b0;
  localparam logic CH_RESPONSE = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic                 in_is_response;
    logic                 in_is_tail;
    logic [PAYLOAD_W-1:0] in_payload;
  } flit_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 out_is_tail;
    logic                 out_is_response;
  } flit_res_t;

endpackage

`default_nettype wire

// ===== hdl/two_channel_flit_fifo_arbiter.sv =====
`default_nettype none

// Flit input buffer with a request queue and a response queue, each
// QUEUE_DEPTH flits deep, and a packet-wise round-robin output arbiter.
//
// Command channel: a beat (push or pull) is taken at a rising edge where
// start is high and busy is low. Result channel: valid_o marks res_o for
// exactly one cycle; there is no back pressure, so every result must be
// taken in the cycle it is shown.
//
// Timing: a command taken at an edge is registered there, executed against
// the queue state in the following cycle; its result is registered as that
// cycle ends and is shown for one cycle. Throughput is one command per clock
// while busy is low; each queue has a single write port and a single registered
// read port that always prefetches the next head flit, which sets that rate.
//
// Reset: both queues empty, no packet open on either side, arbiter on the
// request queue. busy is high during reset and for one cycle after it.
// A push into a full queue returns a full status and changes nothing; a pull
// that finds nothing to send returns an empty status and changes nothing.
module two_channel_flit_fifo_arbiter #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned FLIT_WIDTH  = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  output logic                  busy,
  input  tcffa_pkg::flit_cmd_t  item_i,
  output logic                  valid_o,
  output tcffa_pkg::flit_res_t  res_o
);

  import tcffa_pkg::*;

  localparam int unsigned IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned WORD_W = FLIT_WIDTH + 1;

  // Command register
  logic      busy_q;
  logic      cmd_vld_q;
  flit_cmd_t cmd_q;

  // Queue state, index 0 request, index 1 response
  logic [IDX_W-1:0]  head_q [2];
  logic [IDX_W-1:0]  head_d [2];
  logic [CNT_W-1:0]  cnt_q  [2];
  logic [CNT_W-1:0]  cnt_d  [2];
  logic [IDX_W-1:0]  tail   [2];
  logic [WORD_W-1:0] head_word_q [2];
  logic [1:0]        push_en;
  logic [1:0]        pop_en;
  logic [WORD_W-1:0] wr_word;

  // Packet tracking
  logic in_open_q, in_open_d, in_resp_q, in_resp_d;
  logic out_open_q, out_open_d, out_resp_q, out_resp_d;

  flit_res_t res_d;

  assign busy = busy_q;

  // Take a beat whenever start is seen and busy is low
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      cmd_vld_q <= 1'b0;
    end else begin
      busy_q    <= 1'b0;
      cmd_vld_q <= start && !busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      cmd_q <= item_i;
    end
  end

  // Build the stored word: tail bit above the kept payload bits
  logic [2*PAYLOAD_W-1:0] in_wide;
  assign in_wide = (2*PAYLOAD_W)'(cmd_q.in_payload);
  assign wr_word = {cmd_q.in_is_tail, in_wide[FLIT_WIDTH-1:0]};

  // Execute one command against the queue state
  always_comb begin
    logic                   target;
    logic                   chan;
    logic                   found;
    logic [WORD_W-1:0]      word;
    logic [2*PAYLOAD_W-1:0] out_wide;
    push_en    = 2'b00;
    pop_en     = 2'b00;
    in_open_d  = in_open_q;
    in_resp_d  = in_resp_q;
    out_open_d = out_open_q;
    out_resp_d = out_resp_q;
    res_d      = '0;
    target     = in_open_q ? in_resp_q : cmd_q.in_is_response;
    chan       = out_resp_q;
    found      = 1'b1;
    word       = '0;
    out_wide   = '0;
    if (cmd_vld_q) begin
      if (cmd_q.cmd == CMD_PUSH) begin
        if (cnt_q[target] == CNT_W'(QUEUE_DEPTH)) begin
          res_d.status = ST_FULL;
        end else begin
          push_en[target] = 1'b1;
          in_resp_d       = target;
          in_open_d       = !cmd_q.in_is_tail;
          res_d.status    = ST_DONE;
        end
      end else begin
        // Pick the queue: locked mid-packet, else round robin over non-empty
        if (!out_open_q) begin
          if (cnt_q[CH_RESPONSE] != '0 && cnt_q[CH_REQUEST] != '0) begin
            chan = !out_resp_q;
          end else if (cnt_q[CH_RESPONSE] != '0) begin
            chan = CH_RESPONSE;
          end else if (cnt_q[CH_REQUEST] != '0) begin
            chan = CH_REQUEST;
          end else begin
            found = 1'b0;
          end
        end
        if (!found || cnt_q[chan] == '0) begin
          res_d.status = ST_EMPTY;
        end else begin
          pop_en[chan]          = 1'b1;
          word                  = head_word_q[chan];
          out_wide              = (2*PAYLOAD_W)'(word[FLIT_WIDTH-1:0]);
          out_resp_d            = chan;
          out_open_d            = !word[FLIT_WIDTH];
          res_d.status          = ST_DONE;
          res_d.out_payload     = out_wide[PAYLOAD_W-1:0];
          res_d.out_is_tail     = word[FLIT_WIDTH];
          res_d.out_is_response = chan;
        end
      end
    end
  end

  // Hold packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_open_q  <= 1'b0;
      in_resp_q  <= CH_REQUEST;
      out_open_q <= 1'b0;
      out_resp_q <= CH_REQUEST;
      valid_o    <= 1'b0;
    end else begin
      in_open_q  <= in_open_d;
      in_resp_q  <= in_resp_d;
      out_open_q <= out_open_d;
      out_resp_q <= out_resp_d;
      valid_o    <= cmd_vld_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_vld_q) begin
      res_o <= res_d;
    end
  end

  // One queue per channel
  for (genvar c = 0; c < 2; c++) begin : g_queue
    logic [WORD_W-1:0] mem [QUEUE_DEPTH];
    logic [SUM_W-1:0]  sum;

    // Wrap head plus count into the write address
    assign sum     = SUM_W'(head_q[c]) + SUM_W'(cnt_q[c]);
    assign tail[c] = (sum >= SUM_W'(QUEUE_DEPTH)) ? IDX_W'(sum - SUM_W'(QUEUE_DEPTH))
                                                  : IDX_W'(sum);

    // Advance head and count
    always_comb begin
      head_d[c] = head_q[c];
      cnt_d[c]  = cnt_q[c];
      if (pop_en[c]) begin
        head_d[c] = (head_q[c] == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q[c] + 1'b1;
        cnt_d[c]  = cnt_q[c] - 1'b1;
      end else if (push_en[c]) begin
        cnt_d[c]  = cnt_q[c] + 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        head_q[c] <= '0;
        cnt_q[c]  <= '0;
      end else begin
        head_q[c] <= head_d[c];
        cnt_q[c]  <= cnt_d[c];
      end
    end

    // Write the pushed flit; prefetch the next head, bypassing a same-cycle write
    always_ff @(posedge clk_i) begin
      if (push_en[c]) begin
        mem[tail[c]] <= wr_word;
      end
      if (push_en[c] && tail[c] == head_d[c]) begin
        head_word_q[c] <= wr_word;
      end else begin
        head_word_q[c] <= mem[head_d[c]];
      end
    end
  end

endmodule

`default_nettype wire
